[hw/rtl/dib_pkg.sv]
package dib_pkg;

   // sizes
   localparam int MAX_DELAY    = 255;
   localparam int RING_DEPTH   = MAX_DELAY + 1;
   localparam int RING_AW      = $clog2(RING_DEPTH);
   localparam int FILTER_ORDER = 2;
   localparam int SAMPLE_W     = 16;
   localparam int COEF_W       = 16;
   localparam int DELAY_W      = 8;
   localparam int PROD_W       = SAMPLE_W + COEF_W;
   localparam int ACC_W        = 40;
   // |acc| stays below 5 * 2^30, so 34 bits hold its magnitude
   localparam int MAG_W        = 34;
   localparam int DIV_STEPS    = SAMPLE_W;
   localparam int LOOP_W       = $clog2(DIV_STEPS);
   localparam int STEP_W       = 4;
   localparam int CSR_IDX_W    = 3;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY   = 3'd6;

   // microcode step addresses
   localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [STEP_W-1:0] ST_RING  = 4'd1;
   localparam logic [STEP_W-1:0] ST_LDX   = 4'd2;
   localparam logic [STEP_W-1:0] ST_MB0   = 4'd3;
   localparam logic [STEP_W-1:0] ST_MB1   = 4'd4;
   localparam logic [STEP_W-1:0] ST_MB2   = 4'd5;
   localparam logic [STEP_W-1:0] ST_MA1   = 4'd6;
   localparam logic [STEP_W-1:0] ST_MA2   = 4'd7;
   localparam logic [STEP_W-1:0] ST_ACC   = 4'd8;
   localparam logic [STEP_W-1:0] ST_ABS   = 4'd9;
   localparam logic [STEP_W-1:0] ST_DINIT = 4'd10;
   localparam logic [STEP_W-1:0] ST_DIV   = 4'd11;
   localparam logic [STEP_W-1:0] ST_FIN   = 4'd12;
   localparam logic [STEP_W-1:0] ST_ERR   = 4'd13;

   typedef enum logic [2:0] {
      JC_NEXT,
      JC_GOTO,
      JC_WAIT_REQ,
      JC_A0_ZERO,
      JC_LOOP,
      JC_OUT
   } jump_type;

   typedef enum logic [2:0] {
      MS_B0X0,
      MS_B1X1,
      MS_B2X2,
      MS_A1Y1,
      MS_A2Y2
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef struct packed {
      jump_type          jump;
      logic [STEP_W-1:0] target;
      logic              take;
      logic              ring;
      logic              ldx;
      mul_sel_type       mul_sel;
      acc_op_type        acc_op;
      logic              abs_acc;
      logic              div_init;
      logic              div_step;
      logic              loop_ld;
      logic              fin;
      logic              err;
   } ctrl_type;

   typedef struct packed {
      logic out_free;
      logic a0_zero;
      logic clearing;
   } status_type;

   typedef struct packed {
      logic [COEF_W-1:0]  coef_b0;
      logic [COEF_W-1:0]  coef_b1;
      logic [COEF_W-1:0]  coef_b2;
      logic [COEF_W-1:0]  coef_a0;
      logic [COEF_W-1:0]  coef_a1;
      logic [COEF_W-1:0]  coef_a2;
      logic [DELAY_W-1:0] delay_steps;
   } cfg_type;

   // control store
   function automatic ctrl_type ucode(input logic [STEP_W-1:0] step);
      ctrl_type cw;
      cw         = '0;
      cw.jump    = JC_NEXT;
      cw.target  = ST_IDLE;
      cw.mul_sel = MS_B0X0;
      cw.acc_op  = ACC_HOLD;
      unique case (step)
         ST_IDLE: begin
            cw.take = 1'b1;
            cw.jump = JC_WAIT_REQ;
         end
         ST_RING: begin
            cw.ring   = 1'b1;
            cw.jump   = JC_A0_ZERO;
            cw.target = ST_ERR;
         end
         ST_LDX:   cw.ldx = 1'b1;
         ST_MB0:   cw.mul_sel = MS_B0X0;
         ST_MB1: begin
            cw.mul_sel = MS_B1X1;
            cw.acc_op  = ACC_LOAD;
         end
         ST_MB2: begin
            cw.mul_sel = MS_B2X2;
            cw.acc_op  = ACC_ADD;
         end
         ST_MA1: begin
            cw.mul_sel = MS_A1Y1;
            cw.acc_op  = ACC_ADD;
         end
         ST_MA2: begin
            cw.mul_sel = MS_A2Y2;
            cw.acc_op  = ACC_SUB;
         end
         ST_ACC:   cw.acc_op = ACC_SUB;
         ST_ABS:   cw.abs_acc = 1'b1;
         ST_DINIT: begin
            cw.div_init = 1'b1;
            cw.loop_ld  = 1'b1;
         end
         ST_DIV: begin
            cw.div_step = 1'b1;
            cw.jump     = JC_LOOP;
         end
         ST_FIN: begin
            cw.fin    = 1'b1;
            cw.jump   = JC_OUT;
            cw.target = ST_IDLE;
         end
         ST_ERR: begin
            cw.err    = 1'b1;
            cw.jump   = JC_OUT;
            cw.target = ST_IDLE;
         end
         default: cw.jump = JC_GOTO;
      endcase
      return cw;
   endfunction

endpackage

[hw/rtl/dib_ram.sv]
module dib_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/dib_seq.sv]
module dib_seq import dib_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  status_type status,
   output logic       req_tready,
   output ctrl_type   ctrl
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [LOOP_W-1:0] loop_ff, loop_in;
   logic              accept;

   assign ctrl       = ucode(step_ff);
   assign req_tready = ctrl.take && !status.clearing;
   assign accept     = req_tready && req_tvalid;

   always_comb begin
      step_in = step_ff + 1'b1;
      loop_in = loop_ff;
      if (ctrl.loop_ld) begin
         loop_in = LOOP_W'(DIV_STEPS - 1);
      end
      unique case (ctrl.jump)
         JC_NEXT:     step_in = step_ff + 1'b1;
         JC_GOTO:     step_in = ctrl.target;
         JC_WAIT_REQ: step_in = accept ? step_ff + 1'b1 : step_ff;
         JC_A0_ZERO:  step_in = status.a0_zero ? ctrl.target : step_ff + 1'b1;
         JC_LOOP: begin
            if (loop_ff != '0) begin
               step_in = step_ff;
               loop_in = loop_ff - 1'b1;
            end
         end
         JC_OUT:      step_in = status.out_free ? ctrl.target : step_ff;
         default:     step_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         loop_ff <= '0;
      end else begin
         step_ff <= step_in;
         loop_ff <= loop_in;
      end
   end

   // the divide loop counter only runs inside the divide step
   a_loop_in_div: assert property (@(posedge clock) disable iff (reset)
      loop_ff != '0 |-> step_ff == ST_DIV)
      else $error("loop counter live outside divide step");

endmodule

[hw/rtl/dib_dp.sv]
module dib_dp import dib_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  ctrl_type            ctrl,
   input  logic                req_accept,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                rsp_tready,
   output status_type          status,
   output logic                rsp_tvalid,
   output logic [SAMPLE_W-1:0] rsp_sample,
   output logic                rsp_error,
   output logic                ram_we,
   output logic [RING_AW-1:0]  ram_waddr,
   output logic [SAMPLE_W-1:0] ram_wdata,
   output logic [RING_AW-1:0]  ram_raddr,
   input  logic [SAMPLE_W-1:0] ram_rdata
);

   logic [SAMPLE_W-1:0]        sample_ff, sample_in;
   logic [SAMPLE_W-1:0]        x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in;
   logic [SAMPLE_W-1:0]        y1_ff, y1_in, y2_ff, y2_in;
   logic                       use_ring_ff, use_ring_in;
   logic [RING_AW-1:0]         ptr_ff, ptr_in;
   logic                       clr_busy_ff, clr_busy_in;
   logic [RING_AW-1:0]         clr_ff, clr_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic                       ovf_ff, ovf_in;
   logic [SAMPLE_W-1:0]        rem_ff, rem_in;
   logic [SAMPLE_W-1:0]        dq_ff, dq_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_sample_ff, rsp_sample_in;
   logic                       rsp_error_ff, rsp_error_in;

   logic                       a0_zero, out_free, ring_act, load_fin, load_err;
   logic [RING_AW-1:0]         nd;
   logic [RING_AW:0]           rd_sum, rd_wrap;
   logic [COEF_W-1:0]          dvs;
   logic signed [COEF_W-1:0]   mul_c;
   logic signed [SAMPLE_W-1:0] mul_s;
   logic signed [ACC_W-1:0]    prod_ext, acc_neg;
   logic [SAMPLE_W:0]          trial, trial_sub;
   logic                       trial_ge;
   logic [SAMPLE_W-1:0]        y;

   assign a0_zero  = cfg.coef_a0 == '0;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load_fin = ctrl.fin && out_free;
   assign load_err = ctrl.err && out_free;

   assign status.out_free = out_free;
   assign status.a0_zero  = a0_zero;
   assign status.clearing = clr_busy_ff;

   // delay clipped to the ring; read address wraps modulo the ring depth
   assign nd = (32'(cfg.delay_steps) > MAX_DELAY) ? RING_AW'(MAX_DELAY)
                                                  : RING_AW'(cfg.delay_steps);
   assign ring_act = ctrl.ring && !a0_zero && (nd != '0);
   assign rd_sum   = {1'b0, ptr_ff} + {1'b0, nd};
   assign rd_wrap  = rd_sum - (RING_AW+1)'(RING_DEPTH);

   assign ram_we    = clr_busy_ff || ring_act;
   assign ram_waddr = clr_busy_ff ? clr_ff : ptr_ff;
   assign ram_wdata = clr_busy_ff ? '0 : sample_ff;
   assign ram_raddr = (rd_sum >= (RING_AW+1)'(RING_DEPTH)) ? rd_wrap[RING_AW-1:0]
                                                          : rd_sum[RING_AW-1:0];

   // divisor magnitude; 0x8000 stays correct as unsigned
   assign dvs = cfg.coef_a0[COEF_W-1] ? (~cfg.coef_a0 + 1'b1) : cfg.coef_a0;

   always_comb begin
      mul_c = '0;
      mul_s = '0;
      case (ctrl.mul_sel)
         MS_B0X0: begin
            mul_c = $signed(cfg.coef_b0);
            mul_s = $signed(x0_ff);
         end
         MS_B1X1: begin
            mul_c = $signed(cfg.coef_b1);
            mul_s = $signed(x1_ff);
         end
         MS_B2X2: begin
            mul_c = (FILTER_ORDER >= 2) ? $signed(cfg.coef_b2) : '0;
            mul_s = $signed(x2_ff);
         end
         MS_A1Y1: begin
            mul_c = $signed(cfg.coef_a1);
            mul_s = $signed(y1_ff);
         end
         MS_A2Y2: begin
            mul_c = (FILTER_ORDER >= 2) ? $signed(cfg.coef_a2) : '0;
            mul_s = $signed(y2_ff);
         end
         default: begin
            mul_c = '0;
            mul_s = '0;
         end
      endcase
   end

   assign prod_in  = PROD_W'(mul_c) * PROD_W'(mul_s);
   assign prod_ext = ACC_W'(prod_ff);
   assign acc_neg  = -acc_ff;

   // one restoring divide step per cycle
   assign trial     = {rem_ff, dq_ff[SAMPLE_W-1]};
   assign trial_sub = trial - {1'b0, dvs};
   assign trial_ge  = trial >= {1'b0, dvs};

   // sign and saturate the quotient magnitude
   always_comb begin
      if (neg_ff) begin
         y = (ovf_ff || dq_ff > SAMPLE_MIN) ? SAMPLE_MIN : (~dq_ff + 1'b1);
      end else begin
         y = (ovf_ff || dq_ff[SAMPLE_W-1]) ? SAMPLE_MAX : dq_ff;
      end
   end

   always_comb begin
      sample_in     = req_accept ? req_sample : sample_ff;
      use_ring_in   = ctrl.ring ? ring_act : use_ring_ff;
      ptr_in        = ptr_ff;
      if (ring_act) begin
         ptr_in = (ptr_ff == '0) ? RING_AW'(MAX_DELAY) : ptr_ff - 1'b1;
      end
      clr_in        = clr_busy_ff ? clr_ff + 1'b1 : clr_ff;
      clr_busy_in   = clr_busy_ff && (clr_ff != RING_AW'(MAX_DELAY));
      x0_in         = ctrl.ldx ? (use_ring_ff ? ram_rdata : sample_ff) : x0_ff;

      case (ctrl.acc_op)
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:  acc_in = acc_ff;
      endcase

      mag_in = mag_ff;
      neg_in = neg_ff;
      if (ctrl.abs_acc) begin
         mag_in = acc_ff[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_ff[MAG_W-1:0];
         neg_in = acc_ff[ACC_W-1] ^ cfg.coef_a0[COEF_W-1];
      end

      ovf_in = ovf_ff;
      rem_in = rem_ff;
      dq_in  = dq_ff;
      if (ctrl.div_init) begin
         ovf_in = mag_ff >= MAG_W'({dvs, {DIV_STEPS{1'b0}}});
         rem_in = mag_ff[2*SAMPLE_W-1:SAMPLE_W];
         dq_in  = mag_ff[SAMPLE_W-1:0];
      end else if (ctrl.div_step) begin
         rem_in = trial_ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
         dq_in  = {dq_ff[SAMPLE_W-2:0], trial_ge};
      end

      x1_in = x1_ff;
      x2_in = x2_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      if (load_fin) begin
         if (FILTER_ORDER >= 2) begin
            x2_in = x1_ff;
            y2_in = y1_ff;
         end
         x1_in = x0_ff;
         y1_in = y;
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sample_in = rsp_sample_ff;
      rsp_error_in  = rsp_error_ff;
      if (load_fin) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = y;
         rsp_error_in  = 1'b0;
      end else if (load_err) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = '0;
         rsp_error_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ring_ff  <= 1'b0;
         ptr_ff       <= RING_AW'(MAX_DELAY);
         clr_busy_ff  <= 1'b1;
         clr_ff       <= '0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         use_ring_ff  <= use_ring_in;
         ptr_ff       <= ptr_in;
         clr_busy_ff  <= clr_busy_in;
         clr_ff       <= clr_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff     <= sample_in;
      x0_ff         <= x0_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      ovf_ff        <= ovf_in;
      rem_ff        <= rem_in;
      dq_ff         <= dq_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_error  = rsp_error_ff;

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clr_busy_ff |=> !clr_busy_ff)
      else $error("ring clear restarted");

   a_ptr_moves_on_ring: assert property (@(posedge clock) disable iff (reset)
      !ring_act |=> $stable(ptr_ff))
      else $error("ring pointer moved without a ring access");

   a_err_keeps_state: assert property (@(posedge clock) disable iff (reset)
      ctrl.err |=> $stable(y1_ff) && $stable(x1_ff))
      else $error("history changed on zero divisor");

   a_err_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_error_ff |-> rsp_sample_ff == '0)
      else $error("error response with nonzero sample");

endmodule

[hw/rtl/delayed_iir_biquad.sv]
// Delayed second-order IIR section. Each request sample first goes through
// a pure delay of delay_steps samples held in a 256-entry ring, then a
// direct-form-I biquad forms b0*x0 + b1*x1 + b2*x2 - a1*y1 - a2*y2 in a
// 40-bit accumulator (samples Q1.15, coefficients Q2.13), divides by a0
// with truncation toward zero and saturates to 16 bits. Zero b2/a2 give a
// first-order section. With a0 = 0 the response carries sample 0 and
// coef_error = 1, and neither the ring nor the histories change.
// Requests are handled one at a time, the next taken only back in idle;
// each uses one shared 16x16 multiplier for five products and a 16-step
// serial restoring divider, both skipped when a0 is zero.
// A new request is accepted while the previous response still waits in
// the output register; a waiting response holds the finish step only when
// the next response is ready to be written. After reset the ring is swept
// to zero, one entry per cycle, across all 256 entries; requests are not
// accepted during the sweep, CSR writes are. Write CSRs only while idle.
module delayed_iir_biquad import dib_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request: tdata = sample_in[15:0]
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,
   // response: tdata = sample_out[15:0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]  rsp_tdata,
   // response: tuser = coef_error[0]
   output logic                 rsp_tuser,
   // CSR write port
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   cfg_type                cfg_ff, cfg_in;
   ctrl_type               ctrl;
   status_type             status;
   logic                   req_accept;
   logic                   ram_we;
   logic [RING_AW-1:0]     ram_waddr, ram_raddr;
   logic [SAMPLE_W-1:0]    ram_wdata, ram_rdata;

   // CSR decode; an index past the list is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEF_B0: cfg_in.coef_b0     = csr_wdata;
            CSR_COEF_B1: cfg_in.coef_b1     = csr_wdata;
            CSR_COEF_B2: cfg_in.coef_b2     = csr_wdata;
            CSR_COEF_A0: cfg_in.coef_a0     = csr_wdata;
            CSR_COEF_A1: cfg_in.coef_a1     = csr_wdata;
            CSR_COEF_A2: cfg_in.coef_a2     = csr_wdata;
            CSR_DELAY:   cfg_in.delay_steps = csr_wdata[DELAY_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_b0     <= COEF_W'(8192);
         cfg_ff.coef_b1     <= '0;
         cfg_ff.coef_b2     <= '0;
         cfg_ff.coef_a0     <= COEF_W'(8192);
         cfg_ff.coef_a1     <= '0;
         cfg_ff.coef_a2     <= '0;
         cfg_ff.delay_steps <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_accept = req_tvalid && req_tready;

   // microcode sequencer: step counter, divide loop counter, control store
   dib_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .req_tready (req_tready),
      .ctrl       (ctrl)
   );

   // datapath: multiplier, accumulator, divider, histories, output register
   dib_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .ctrl       (ctrl),
      .req_accept (req_accept),
      .req_sample (req_tdata),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_sample (rsp_tdata),
      .rsp_error  (rsp_tuser),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   // delay ring
   dib_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
